[rtl/core/xor_sentence_frame_checker_core_assert.svh]
// Assertion macros for the sentence frame checker core.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef XOR_SENTENCE_FRAME_CHECKER_CORE_ASSERT_SVH
`define XOR_SENTENCE_FRAME_CHECKER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define XSFC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("xsfc assertion failed");
`define XSFC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("xsfc next-cycle assertion failed");
`else
`define XSFC_ASSERT(lbl, prop)
`define XSFC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/core/xsfc_pkg.sv]
// Shared types and constants for the sentence frame checker.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps
`default_nettype none

package xsfc_pkg;

	localparam int BUFFER_BYTES    = 128;
	localparam int FRAME_LIMIT     = ((BUFFER_BYTES - 3) < 127) ? (BUFFER_BYTES - 3) : 127;
	localparam int STAR_MIN_OFFSET = 5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef logic [7:0] byte_t;
	typedef logic [6:0] count_t;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_BODY  = 2'd1,
		PH_FIELD = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_STAR   = 3'd1,
		ST_BAD_FIELD = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_OVERRUN   = 3'd4
	} status_t;

	typedef struct packed {
		phase_t phase;
		logic   pending_cr;
		byte_t  xor_accum;
		byte_t  hex_value;
		logic   hex_too_big;
		logic   hex_digit_seen;
		logic   hex_bad_char;
		count_t byte_count;
	} xsfc_state_t;

	typedef struct packed {
		status_t status;
		count_t  length;
		byte_t   computed;
		byte_t   received;
	} xsfc_result_t;

	localparam count_t LIMIT_CNT    = count_t'(FRAME_LIMIT);
	localparam count_t STAR_MIN_CNT = count_t'(STAR_MIN_OFFSET);

	localparam xsfc_state_t STATE_CLEAR = '{
		phase: PH_HUNT, pending_cr: 1'b0, xor_accum: 8'h00, hex_value: 8'h00,
		hex_too_big: 1'b0, hex_digit_seen: 1'b0, hex_bad_char: 1'b0,
		byte_count: 7'd0
	};

	localparam xsfc_state_t STATE_START = '{
		phase: PH_BODY, pending_cr: 1'b0, xor_accum: 8'h00, hex_value: 8'h00,
		hex_too_big: 1'b0, hex_digit_seen: 1'b0, hex_bad_char: 1'b0,
		byte_count: 7'd1
	};

endpackage

`default_nettype wire

[rtl/core/xsfc_rx_if.sv]
// Valid/ready channel carrying received serial bytes.
// Depends on xsfc_pkg for the byte type.
`timescale 1ns / 1ps
`default_nettype none

interface xsfc_rx_if import xsfc_pkg::*; ();

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

[rtl/core/xsfc_res_if.sv]
// Valid/ready channel carrying one frame verdict per transfer.
// Depends on xsfc_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface xsfc_res_if import xsfc_pkg::*; ();

	logic       valid;
	logic       ready;
	logic [2:0] frame_status;
	count_t     frame_length;
	byte_t      computed_checksum;
	byte_t      received_checksum;

	modport source (output valid, output frame_status, output frame_length,
		output computed_checksum, output received_checksum, input ready);
	modport sink (input valid, input frame_status, input frame_length,
		input computed_checksum, input received_checksum, output ready);

endinterface

`default_nettype wire

[rtl/core/xor_sentence_frame_checker_core.sv]
// Top level of the NMEA-style sentence checksum checker.
// Depends on xsfc_pkg, xsfc_rx_if, xsfc_res_if, xsfc_take and the assert header.
//
//   Channel | Direction | Payload                                        | Handshake
//   rx      | in        | rx_byte                                        | valid/ready
//   res     | out       | frame_status, frame_length, computed/received  | valid/ready
//   cfg     | in        | cfg_wdata (receive_enable)                     | cfg_we only
//
// One byte is taken per cycle, back to back. A transferred byte is held in an input
// register, then the parser state is updated and any verdict is written into the
// result register, from which it is offered on res. A full result register that
// is not taken stalls the input register, and the input channel drops ready only
// when both are held. Reset clears the parser to hunting and disables reception.
`timescale 1ns / 1ps
`default_nettype none

`include "xor_sentence_frame_checker_core_assert.svh"

module xor_sentence_frame_checker_core import xsfc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	xsfc_rx_if.sink        rx,
	xsfc_res_if.source     res
);

	// Input register stage.
	logic  rx_valid_s1;
	byte_t rx_byte_s1;

	// Parser state and the enable register.
	xsfc_state_t state_q;
	logic        enable_q;

	// Result register.
	logic         res_valid_q;
	xsfc_result_t res_q;

	// Step logic.
	logic         advance;
	xsfc_state_t  state_d;
	logic         res_v;
	xsfc_result_t res_d;
	xsfc_result_t end_res;
	xsfc_state_t  cr_nxt;
	logic         cr_ovf;
	xsfc_result_t cr_res;
	xsfc_state_t  data_in;
	xsfc_state_t  data_nxt;
	logic         data_ovf;
	xsfc_result_t data_res;

	// The stage moves whenever the result register is empty or being drained.
	assign advance  = !res_valid_q || res.ready;
	assign rx.ready = !rx_valid_s1 || advance;

	// A CR held back from the previous byte turns out to be data when the
	// current byte is not LF; it is stored first, then the current byte.
	xsfc_take u_take_cr (
		.st      (state_q),
		.data    (CH_CR),
		.nxt     (cr_nxt),
		.ovf     (cr_ovf),
		.ovf_res (cr_res)
	);

	assign data_in = state_q.pending_cr ? cr_nxt : state_q;

	xsfc_take u_take_data (
		.st      (data_in),
		.data    (rx_byte_s1),
		.nxt     (data_nxt),
		.ovf     (data_ovf),
		.ovf_res (data_res)
	);

	// Verdict at CR LF. Without a star the whole body was XORed.
	always_comb begin
		end_res.length   = state_q.byte_count;
		end_res.computed = state_q.xor_accum;
		end_res.received = (state_q.phase == PH_FIELD) ? state_q.hex_value : 8'h00;
		if (state_q.phase == PH_BODY) begin
			end_res.status = ST_NO_STAR;
		end else if (!state_q.hex_digit_seen || state_q.hex_bad_char) begin
			end_res.status = ST_BAD_FIELD;
		end else if (state_q.hex_too_big || state_q.hex_value != state_q.xor_accum) begin
			end_res.status = ST_MISMATCH;
		end else begin
			end_res.status = ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		res_v   = 1'b0;
		res_d   = data_res;
		if (!enable_q) begin
			state_d = STATE_CLEAR;
		end else if (state_q.phase != PH_BODY && state_q.phase != PH_FIELD) begin
			// Hunting: only a dollar sign opens a frame.
			state_d = (rx_byte_s1 == CH_DOLLAR) ? STATE_START : STATE_CLEAR;
		end else if (state_q.pending_cr && rx_byte_s1 == CH_LF) begin
			res_v   = 1'b1;
			res_d   = end_res;
			state_d = STATE_CLEAR;
		end else if (state_q.pending_cr && cr_ovf) begin
			// The held CR overflowed; a dollar sign right after it opens a frame.
			res_v   = 1'b1;
			res_d   = cr_res;
			state_d = (rx_byte_s1 == CH_DOLLAR) ? STATE_START : STATE_CLEAR;
		end else if (rx_byte_s1 == CH_CR) begin
			state_d = data_in;
			state_d.pending_cr = 1'b1;
		end else begin
			state_d = data_nxt;
			res_v   = data_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			rx_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// A configuration write always restarts the parser.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			state_q  <= STATE_CLEAR;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
			state_q  <= STATE_CLEAR;
		end else if (rx_valid_s1 && advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= rx_valid_s1 && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rx_valid_s1 && res_v) begin
			res_q <= res_d;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.frame_status      = res_q.status;
	assign res.frame_length      = res_q.length;
	assign res.computed_checksum = res_q.computed;
	assign res.received_checksum = res_q.received;

	`XSFC_ASSERT(a_ok_match, res_valid_q && res_q.status == ST_OK |-> res_q.computed == res_q.received)
	`XSFC_ASSERT(a_nostar_zero, res_valid_q && res_q.status == ST_NO_STAR |-> res_q.received == 8'h00)
	`XSFC_ASSERT(a_overrun_len, res_valid_q && res_q.status == ST_OVERRUN |-> res_q.length == LIMIT_CNT)
	`XSFC_ASSERT(a_hunt_clean, state_q.phase == PH_HUNT |-> state_q.byte_count == 7'd0 && !state_q.pending_cr)
	`XSFC_ASSERT_NEXT(a_cfg_clears, cfg_we, state_q.phase == PH_HUNT && state_q.byte_count == 7'd0)

endmodule

`default_nettype wire

[rtl/core/xsfc_take.sv]
// Stores one data byte of an open frame: checksum, star detection, hex field.
// Depends on xsfc_pkg for the parser state and result types.
`timescale 1ns / 1ps
`default_nettype none

module xsfc_take import xsfc_pkg::*; (
	input  xsfc_state_t  st,
	input  byte_t        data,
	output xsfc_state_t  nxt,
	output logic         ovf,
	output xsfc_result_t ovf_res
);

	function automatic logic [4:0] hex_digit(input byte_t b);
		logic [4:0] r;
		byte_t      t;
		r = 5'd0;
		t = 8'h00;
		if (b >= 8'h30 && b <= 8'h39) begin
			t = b - 8'h30;
			r = {1'b1, t[3:0]};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			t = b - 8'h37;
			r = {1'b1, t[3:0]};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			t = b - 8'h57;
			r = {1'b1, t[3:0]};
		end
		return r;
	endfunction

	logic [4:0] digit;

	assign digit = hex_digit(data);

	always_comb begin
		nxt = st;
		nxt.pending_cr = 1'b0;
		ovf = 1'b0;
		ovf_res.status   = ST_OVERRUN;
		ovf_res.length   = st.byte_count;
		ovf_res.computed = st.xor_accum;
		ovf_res.received = (st.phase == PH_FIELD) ? st.hex_value : 8'h00;
		if (st.byte_count >= LIMIT_CNT) begin
			ovf = 1'b1;
			nxt = STATE_CLEAR;
		end else begin
			nxt.byte_count = st.byte_count + 7'd1;
			if (st.phase == PH_BODY) begin
				if (data == CH_STAR && st.byte_count >= STAR_MIN_CNT) begin
					nxt.phase = PH_FIELD;
				end else begin
					nxt.xor_accum = st.xor_accum ^ data;
				end
			end else if (!digit[4]) begin
				nxt.hex_bad_char = 1'b1;
			end else begin
				if (|st.hex_value[7:4]) begin
					nxt.hex_too_big = 1'b1;
				end
				nxt.hex_value = {st.hex_value[3:0], digit[3:0]};
				nxt.hex_digit_seen = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[dv/tb_xor_sentence_frame_checker_core.sv]
// Self-checking testbench for xor_sentence_frame_checker_core.
// Depends on xsfc_pkg, xsfc_rx_if, xsfc_res_if and the core itself; reads nothing else.
`timescale 1ns / 1ps

module tb_xor_sentence_frame_checker_core;
	import xsfc_pkg::*;

	// Clocks allowed before the run is declared hung. The limit leaves plenty of room
	// for the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;
	// A verdict passes through the input and result registers after the byte that
	// closes the frame; wait past that before touching the register or ending the run.
	localparam int DRAIN_CYCLES = 8;
	localparam int N_PHASES = 11;

	// Shapes of checksum field that the sentence generator can produce.
	typedef enum int {
		FLD_GOOD, FLD_WRONG, FLD_EMPTY, FLD_BADCH, FLD_BIG, FLD_ZPAD, FLD_NONE, FLD_TRUNC
	} field_mode_t;

	// One row of the directed table: either a register write or one byte, with the
	// verdict typed in by hand where it is obvious.
	typedef struct {
		bit           is_cfg;
		bit           en;
		byte_t        data;
		bit           typed;
		xsfc_result_t res;
	} tab_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	xsfc_rx_if  byte_ch ();
	xsfc_res_if verdict_ch ();

	xor_sentence_frame_checker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (byte_ch),
		.res       (verdict_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bytes to send, in order, with an optional hand-typed verdict per byte.
	byte_t        tx_bytes [$];
	bit           tx_typed [$];
	xsfc_result_t tx_res   [$];
	tab_row_t     dir_tab  [$];

	// Verdicts the core still owes us, oldest first.
	xsfc_result_t verdict_q [$];

	// Predictor copy of the register and of the parser.
	bit          rx_on = 1'b0;
	xsfc_state_t frame_st = STATE_CLEAR;

	int n_taken = 0;
	int tx_ptr  = 0;
	int errors  = 0;
	int cyc     = 0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic xsfc_result_t frame_verdict(input status_t st);
		xsfc_result_t r;
		r.status   = st;
		r.length   = frame_st.byte_count;
		r.computed = frame_st.xor_accum;
		r.received = (frame_st.phase == PH_FIELD) ? frame_st.hex_value : 8'h00;
		return r;
	endfunction

	function automatic bit hex_nibble(input byte_t b, output logic [3:0] n);
		n = 4'h0;
		if (b >= "0" && b <= "9") n = 4'(b - "0");
		else if (b >= "A" && b <= "F") n = 4'(b - "A" + 10);
		else if (b >= "a" && b <= "f") n = 4'(b - "a" + 10);
		else return 1'b0;
		return 1'b1;
	endfunction

	// Put one data byte into the open frame. Returns 1, with the overrun verdict,
	// when the frame has no room left for it.
	function automatic bit store_byte(input byte_t b, output xsfc_result_t r);
		count_t     pos;
		logic [3:0] nib;
		r = '0;
		pos = frame_st.byte_count;
		if (pos >= LIMIT_CNT) begin
			r = frame_verdict(ST_OVERRUN);
			frame_st = STATE_CLEAR;
			return 1'b1;
		end
		frame_st.byte_count = pos + 7'd1;
		if (frame_st.phase == PH_BODY) begin
			// A star too close to the dollar sign is ordinary payload.
			if (b == CH_STAR && pos >= STAR_MIN_CNT) frame_st.phase = PH_FIELD;
			else frame_st.xor_accum ^= b;
		end else if (hex_nibble(b, nib)) begin
			if (frame_st.hex_value[7:4] != 4'h0) frame_st.hex_too_big = 1'b1;
			frame_st.hex_value = {frame_st.hex_value[3:0], nib};
			frame_st.hex_digit_seen = 1'b1;
		end else begin
			frame_st.hex_bad_char = 1'b1;
		end
		return 1'b0;
	endfunction

	// Expected effect of one accepted byte; returns 1 when it yields a verdict.
	function automatic bit predict_byte(input byte_t b, output xsfc_result_t r);
		status_t st;
		r = '0;
		if (!rx_on) begin
			frame_st = STATE_CLEAR;
			return 1'b0;
		end
		if (frame_st.phase != PH_BODY && frame_st.phase != PH_FIELD) begin
			frame_st = (b == CH_DOLLAR) ? STATE_START : STATE_CLEAR;
			return 1'b0;
		end
		if (frame_st.pending_cr) begin
			frame_st.pending_cr = 1'b0;
			if (b == CH_LF) begin
				if (frame_st.phase == PH_BODY) st = ST_NO_STAR;
				else if (!frame_st.hex_digit_seen || frame_st.hex_bad_char) st = ST_BAD_FIELD;
				else if (frame_st.hex_too_big || frame_st.hex_value != frame_st.xor_accum)
					st = ST_MISMATCH;
				else st = ST_OK;
				r = frame_verdict(st);
				frame_st = STATE_CLEAR;
				return 1'b1;
			end
			// A CR without LF is payload; if it overflows the frame the byte after
			// it is looked at again as a possible new dollar sign.
			if (store_byte(CH_CR, r)) begin
				if (b == CH_DOLLAR) frame_st = STATE_START;
				return 1'b1;
			end
		end
		if (b == CH_CR) begin
			frame_st.pending_cr = 1'b1;
			return 1'b0;
		end
		return store_byte(b, r);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------

	function automatic void tx_put(input byte_t b);
		tx_bytes.push_back(b);
		tx_typed.push_back(1'b0);
		tx_res.push_back('0);
	endfunction

	function automatic void tab_byte(input byte_t b);
		tab_row_t row;
		row = '{is_cfg: 1'b0, en: 1'b0, data: b, typed: 1'b0, res: '0};
		dir_tab.push_back(row);
	endfunction

	function automatic void tab_end(input byte_t b, input status_t st, input count_t len,
		input byte_t comp, input byte_t recv);
		tab_row_t row;
		row = '{is_cfg: 1'b0, en: 1'b0, data: b, typed: 1'b1, res: '0};
		row.res = '{status: st, length: len, computed: comp, received: recv};
		dir_tab.push_back(row);
	endfunction

	function automatic void tab_cfg(input bit en);
		tab_row_t row;
		row = '{is_cfg: 1'b1, en: en, data: 8'h00, typed: 1'b0, res: '0};
		dir_tab.push_back(row);
	endfunction

	// Hex digit with random letter case.
	function automatic byte_t hex_char(input logic [3:0] n);
		if (n < 4'd10) return byte_t'("0" + n);
		return byte_t'(($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10));
	endfunction

	// Appends '$', body_len payload bytes and a tail shaped by mode.
	function automatic void push_sentence(input int body_len, input field_mode_t mode);
		byte_t sum;
		byte_t c;
		byte_t fld [$];
		int    k;
		sum = 8'h00;
		tx_put(CH_DOLLAR);
		for (k = 1; k <= body_len; k++) begin
			case ($urandom_range(0, 19))
				0: c = CH_CR;
				1, 2, 3: c = byte_t'($urandom_range(0, 255));
				default: c = byte_t'($urandom_range(8'h20, 8'h7E));
			endcase
			if (c == CH_LF) c = "L";
			// Keep the star out of the body except where it is still plain payload.
			if (c == CH_STAR && k >= STAR_MIN_OFFSET) c = "S";
			sum ^= c;
			tx_put(c);
		end
		if (mode == FLD_TRUNC) return;
		if (mode != FLD_NONE) begin
			tx_put(CH_STAR);
			case (mode)
				FLD_BIG: fld.push_back(hex_char(4'($urandom_range(1, 15))));
				FLD_ZPAD: fld.push_back("0");
				FLD_WRONG: sum ^= byte_t'($urandom_range(1, 255));
				default: ;
			endcase
			if (mode != FLD_EMPTY) begin
				fld.push_back(hex_char(sum[7:4]));
				fld.push_back(hex_char(sum[3:0]));
			end
			if (mode == FLD_BADCH) begin
				case ($urandom_range(0, 5))
					0: c = " ";
					1: c = "-";
					2: c = "x";
					3: c = "G";
					4: c = CH_CR;
					default: c = byte_t'($urandom_range(8'h80, 8'hFF));
				endcase
				fld.insert($urandom_range(0, fld.size()), c);
			end
			foreach (fld[i]) tx_put(fld[i]);
		end
		tx_put(CH_CR);
		tx_put(CH_LF);
	endfunction

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// Wait until every queued byte has been taken and every verdict has come back,
	// then let the pipeline run dry.
	task automatic settle();
		while (n_taken != tx_bytes.size() || verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input bit en);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Byte sender: bursts of random length separated by random gaps. A byte
	// that is offered stays offered, unchanged, until its transfer happens.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) tx_ptr++;
			if (byte_ch.valid && !byte_ch.ready) begin
				// Held: the same byte stays on the channel.
			end else if (gap_left > 0) begin
				gap_left--;
				byte_ch.valid <= 1'b0;
			end else if (tx_ptr < tx_bytes.size()) begin
				byte_ch.valid   <= 1'b1;
				byte_ch.rx_byte <= tx_bytes[tx_ptr];
				burst_left--;
				if (burst_left <= 0) begin
					// Now and then a long burst with no gap at all.
					if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(64, 200);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = $urandom_range(0, 5);
					end
				end
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Verdict receiver: short stalls between runs of ready, with an
	// occasional long stretch of ready so back-to-back verdicts drain freely.
	// ------------------------------------------------------------------
	int rdy_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rdy_left > 0) begin
				rdy_left--;
			end else if (verdict_ch.ready) begin
				verdict_ch.ready <= 1'b0;
				rdy_left = $urandom_range(0, 6);
			end else begin
				verdict_ch.ready <= 1'b1;
				rdy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(0, 12);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every value here is the one that stood before the clock edge,
	// so the order of processes inside the time step does not matter.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		xsfc_result_t pred;
		xsfc_result_t want;
		bit           hit;
		if (arst_n) begin
			// Any register write also puts the parser back to hunting.
			if (cfg_we) begin
				rx_on    = cfg_wdata;
				frame_st = STATE_CLEAR;
			end
			if (byte_ch.valid && byte_ch.ready) begin
				hit = predict_byte(byte_ch.rx_byte, pred);
				// Directed rows with a hand-typed verdict override the predictor.
				if (tx_typed[n_taken]) begin
					hit  = 1'b1;
					pred = tx_res[n_taken];
				end
				if (hit) verdict_q.push_back(pred);
				n_taken++;
			end
			if (verdict_ch.valid && verdict_ch.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: verdict transfer with none expected, actual status %0d length %0d",
						$time, verdict_ch.frame_status, verdict_ch.frame_length);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					check_field("frame_status", 8'(want.status), 8'(verdict_ch.frame_status));
					check_field("frame_length", 8'(want.length), 8'(verdict_ch.frame_length));
					check_field("computed_checksum", want.computed, verdict_ch.computed_checksum);
					check_field("received_checksum", want.received, verdict_ch.received_checksum);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("[xor_sentence_frame_checker_core] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int ph;
		int start;
		int target;
		int sel;
		int k;
		bit en;
		field_mode_t m;

		byte_ch.valid    = 1'b0;
		byte_ch.rx_byte  = 8'h00;
		verdict_ch.ready = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = 1'b0;
		arst_n           = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. Reception is off after reset, so the first two bytes,
		// a dollar sign among them, must vanish without a verdict.
		tab_byte(CH_DOLLAR);
		tab_byte("A");
		tab_cfg(1'b1);
		// Extreme byte values while hunting are ignored.
		tab_byte(8'h00);
		tab_byte(8'hFF);
		// A star too early and a dollar sign inside the frame are payload, and so is
		// a CR that no LF follows. The star at offset five opens the field.
		tab_byte(CH_DOLLAR);
		tab_byte(CH_STAR);
		tab_byte(CH_DOLLAR);
		tab_byte(CH_CR);
		tab_byte("Z");
		tab_byte(CH_STAR);
		tab_byte("5");
		tab_byte("9");
		tab_byte(CH_CR);
		tab_byte(CH_LF);
		// No star at all: the whole body is summed, nothing is received.
		tab_byte(CH_DOLLAR);
		tab_byte("A");
		tab_byte("B");
		tab_byte("C");
		tab_byte("D");
		tab_byte("E");
		tab_byte(CH_CR);
		tab_end(CH_LF, ST_NO_STAR, 7'd6, 8'h41, 8'h00);
		// Shortest possible frame.
		tab_byte(CH_DOLLAR);
		tab_byte(CH_CR);
		tab_end(CH_LF, ST_NO_STAR, 7'd1, 8'h00, 8'h00);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_cfg(dir_tab[i].en);
			end else begin
				tx_bytes.push_back(dir_tab[i].data);
				tx_typed.push_back(dir_tab[i].typed);
				tx_res.push_back(dir_tab[i].res);
			end
		end

		// Random part: one register setting per phase, two phases with reception off.
		for (ph = 0; ph < N_PHASES; ph++) begin
			en = (ph % 4 != 3);
			settle();
			write_cfg(en);
			start  = tx_bytes.size();
			target = en ? 100 : 40;
			case (ph)
				// Frame that overruns the buffer.
				0: push_sentence(130, FLD_GOOD);
				// Buffer full when a lone CR arrives, followed at once by a new frame.
				1: begin
					push_sentence(124, FLD_TRUNC);
					tx_put(CH_CR);
					push_sentence(8, FLD_GOOD);
				end
				// Frame that fills the buffer exactly and still passes.
				2: push_sentence(121, FLD_GOOD);
				default: ;
			endcase
			while (tx_bytes.size() - start < target) begin
				sel = $urandom_range(0, 99);
				k   = $urandom_range(0, 9);
				m   = (k < 4) ? FLD_GOOD : field_mode_t'(k - 3);
				if (sel < 65) begin
					push_sentence(($urandom_range(0, 3) == 0) ? $urandom_range(0, 6)
						: $urandom_range(4, 16), m);
				end else if (sel < 68) begin
					push_sentence($urandom_range(115, 135),
						$urandom_range(0, 1) ? FLD_GOOD : FLD_NONE);
				end else if (sel < 84) begin
					for (k = $urandom_range(1, 8); k > 0; k--)
						tx_put(byte_t'($urandom_range(0, 255)));
				end else begin
					push_sentence($urandom_range(0, 12), FLD_TRUNC);
				end
			end
		end

		settle();
		if (errors == 0) begin
			$display("[xor_sentence_frame_checker_core] OK");
		end else begin
			$display("[xor_sentence_frame_checker_core] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/xsfc_pkg.sv
rtl/core/xsfc_rx_if.sv
rtl/core/xsfc_res_if.sv
rtl/core/xsfc_take.sv
rtl/core/xor_sentence_frame_checker_core.sv
dv/tb_xor_sentence_frame_checker_core.sv
